FILE: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// shared constants, codes and controller/datapath bundles of the region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_REGIONS_DEF = 32;
    localparam int ADDR_BITS       = 32;
    localparam int ALIGN_BITS      = 17;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam logic [1:0] RA_IDX = 2'd0;
    localparam logic [1:0] RA_J   = 2'd1;
    localparam logic [1:0] RA_JM1 = 2'd2;

    localparam logic [2:0] W_NONE  = 3'd0;
    localparam logic [2:0] W_ALLOC = 3'd1;
    localparam logic [2:0] W_DN    = 3'd2;
    localparam logic [2:0] W_UP    = 3'd3;
    localparam logic [2:0] W_MNEXT = 3'd4;
    localparam logic [2:0] W_MBOTH = 3'd5;
    localparam logic [2:0] W_MPREV = 3'd6;
    localparam logic [2:0] W_INS   = 3'd7;

    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_GRANT = 2'd1;
    localparam logic [1:0] RES_NOFIT = 2'd2;
    localparam logic [1:0] RES_FULL  = 2'd3;

    typedef struct packed {
        logic       load_req;
        logic       idx_clr;
        logic       idx_inc;
        logic       lat_cur;
        logic       prv_from_cur;
        logic [1:0] rsel;
        logic [2:0] wsel;
        logic       j_set_idx1;
        logic       j_set_cnt;
        logic       j_inc;
        logic       j_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic [1:0] res_code;
        logic       out_load;
    } t_ffra_cmd;

    typedef struct packed {
        logic act;
        logic idx_lt_cnt;
        logic j_lt_cnt;
        logic j_gt_idx;
        logic mod_busy;
        logic fit;
        logic nl_zero;
        logic start_lt;
        logic mnext;
        logic mprev;
        logic full;
        logic out_free;
    } t_ffra_stat;

    function automatic logic meets(input logic [ADDR_BITS-1:0] a,
                                   input logic [ADDR_BITS-1:0] b,
                                   input logic [ADDR_BITS-1:0] c);
        logic [ADDR_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return !s[ADDR_BITS] && (s[ADDR_BITS-1:0] == c);
    endfunction

    function automatic logic [ADDR_BITS-1:0] sat_add(input logic [ADDR_BITS-1:0] a,
                                                     input logic [ADDR_BITS-1:0] b);
        logic [ADDR_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_BITS] ? {ADDR_BITS{1'b1}} : s[ADDR_BITS-1:0];
    endfunction

endpackage

FILE: rtl/first_fit_region_allocator_core.sv
// allocate: each table entry tried is read, latched, held for the bit-serial alignment
//   remainder when align_to is non-zero and fit-checked; an emptied region is shifted out
// free: entries up to the insertion point are read, latched and compared; entries moved
//   are read and written; requests are accepted in idle and results handed off in S_OUT
// one request in flight at a time: o_in_ready is high only while the sequencer is idle
// synchronous active-low reset reloads the table as one region at base 0, size 65536
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// first-fit free region allocator with coalescing on free
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
    parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_request_size,
    input  logic [ffra_pkg::ALIGN_BITS-1:0]  i_align_to,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_free_offset,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_status,
    output logic [ffra_pkg::ADDR_BITS-1:0]   o_region_offset,
    output logic [ffra_pkg::ADDR_BITS-1:0]   o_region_length
);
    import ffra_pkg::*;

    t_ffra_cmd  w_cmd;
    t_ffra_stat w_stat;

    ffra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ffra_dp #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_request_size  (i_request_size),
        .i_align_to      (i_align_to),
        .i_free_offset   (i_free_offset),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_region_offset (o_region_offset),
        .o_region_length (o_region_length),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );
endmodule

FILE: rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// region table, request registers, alignment remainder unit and result registers
// ----------------------------------------------------------------------------
module ffra_dp #(
    parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_cfg_data,
    input  logic                             i_action,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_request_size,
    input  logic [ffra_pkg::ALIGN_BITS-1:0]  i_align_to,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   i_free_offset,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [1:0]                       o_status,
    output logic [ffra_pkg::ADDR_BITS-1:0]   o_region_offset,
    output logic [ffra_pkg::ADDR_BITS-1:0]   o_region_length,
    input  ffra_pkg::t_ffra_cmd              i_cmd,
    output ffra_pkg::t_ffra_stat             o_stat
);
    import ffra_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int AB = ADDR_BITS;
    localparam int MW = $clog2(AB);

    logic [AB-1:0]         r_heap_base, r_heap_size;
    logic [CW-1:0]         r_count, r_idx, r_j;
    logic                  r_act;
    logic [AB-1:0]         r_size, r_off;
    logic [ALIGN_BITS-1:0] r_align;
    logic [AB-1:0]         r_cur_s, r_cur_l, r_prv_s, r_prv_l;
    logic [ALIGN_BITS-1:0] r_rem;
    logic [AB-1:0]         r_msh;
    logic [MW-1:0]         r_mcnt;
    logic                  r_mbusy;
    logic [1:0]            r_res_st;
    logic [AB-1:0]         r_res_off, r_res_len;
    logic                  r_out_valid;
    logic [1:0]            r_o_status;
    logic [AB-1:0]         r_o_off, r_o_len;

    logic [2*AB-1:0]       w_rdata, w_wdata;
    logic [IW-1:0]         w_waddr, w_raddr;
    logic                  w_we;
    logic [AB-1:0]         w_rd_s, w_rd_l;
    logic [ALIGN_BITS:0]   w_rt;
    logic [ALIGN_BITS-1:0] w_pad;
    logic [AB:0]           w_need;
    logic [AB-1:0]         w_new_s, w_new_l, w_ncur;
    logic [CW-1:0]         w_idx_m1, w_j_m1;
    logic [AB-1:0]         w_cfg_base, w_cfg_size;

    assign w_rd_s   = w_rdata[2*AB-1:AB];
    assign w_rd_l   = w_rdata[AB-1:0];
    assign w_idx_m1 = r_idx - CW'(1);
    assign w_j_m1   = r_j - CW'(1);

    assign w_rt  = {r_rem, r_msh[AB-1]};
    assign w_pad = (r_align == '0 || r_rem == '0) ? '0 : r_align - r_rem;
    assign w_need  = {1'b0, r_size} + {{(AB+1-ALIGN_BITS){1'b0}}, w_pad};
    assign w_new_s = r_cur_s + w_need[AB-1:0];
    assign w_new_l = r_cur_l - w_need[AB-1:0];
    assign w_ncur  = sat_add(r_cur_l, r_size);

    assign w_cfg_base = (i_cfg_index == CFG_BASE) ? i_cfg_data : r_heap_base;
    assign w_cfg_size = (i_cfg_index == CFG_SIZE) ? i_cfg_data : r_heap_size;

    always_comb begin
        unique case (i_cmd.rsel)
            RA_J:    w_raddr = r_j[IW-1:0];
            RA_JM1:  w_raddr = w_j_m1[IW-1:0];
            default: w_raddr = r_idx[IW-1:0];
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_idx[IW-1:0];
        w_wdata = {r_off, r_size};
        if (!i_rst_n) begin
            w_waddr = '0;
            w_wdata = {{AB{1'b0}}, AB'(65536)};
        end else if (i_cfg_we) begin
            w_waddr = '0;
            w_wdata = {w_cfg_base, w_cfg_size};
        end else begin
            unique case (i_cmd.wsel)
                W_ALLOC: w_wdata = {w_new_s, w_new_l};
                W_DN: begin
                    w_waddr = w_j_m1[IW-1:0];
                    w_wdata = w_rdata;
                end
                W_UP: begin
                    w_waddr = r_j[IW-1:0];
                    w_wdata = w_rdata;
                end
                W_MNEXT: w_wdata = {r_off, w_ncur};
                W_MBOTH: begin
                    w_waddr = w_idx_m1[IW-1:0];
                    w_wdata = {r_prv_s, sat_add(r_prv_l, w_ncur)};
                end
                W_MPREV: begin
                    w_waddr = w_idx_m1[IW-1:0];
                    w_wdata = {r_prv_s, sat_add(r_prv_l, r_size)};
                end
                W_INS:   w_wdata = {r_off, r_size};
                default: w_we = 1'b0;
            endcase
        end
    end

    ffra_ram #(
        .WIDTH (2*AB),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_size <= AB'(65536);
            r_count     <= CW'(1);
            r_idx       <= '0;
            r_j         <= '0;
            r_mbusy     <= 1'b0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_base <= w_cfg_base;
                r_heap_size <= w_cfg_size;
                r_count     <= CW'(1);
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.j_set_idx1) begin
                r_j <= r_idx + CW'(1);
            end else if (i_cmd.j_set_cnt) begin
                r_j <= r_count;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + CW'(1);
            end else if (i_cmd.j_dec) begin
                r_j <= w_j_m1;
            end
            if (i_cmd.lat_cur) begin
                r_mbusy <= !r_act && (r_align != '0);
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + MW'(1);
                if (r_mcnt == MW'(AB - 1)) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_act   <= i_action;
            r_size  <= i_request_size;
            r_align <= i_align_to;
            r_off   <= i_free_offset;
        end
        if (i_cmd.lat_cur) begin
            r_cur_s <= w_rd_s;
            r_cur_l <= w_rd_l;
            r_msh   <= w_rd_s;
            r_rem   <= '0;
        end else if (r_mbusy) begin
            r_msh <= {r_msh[AB-2:0], 1'b0};
            r_rem <= (w_rt >= {1'b0, r_align}) ? ALIGN_BITS'(w_rt - {1'b0, r_align})
                                                : ALIGN_BITS'(w_rt);
        end
        if (i_cmd.prv_from_cur) begin
            r_prv_s <= r_cur_s;
            r_prv_l <= r_cur_l;
        end
        if (i_cmd.res_load) begin
            r_res_st  <= ST_OK;
            r_res_off <= '0;
            r_res_len <= '0;
            case (i_cmd.res_code)
                RES_GRANT: begin
                    r_res_off <= r_cur_s;
                    r_res_len <= w_need[AB-1:0];
                end
                RES_NOFIT: r_res_st <= ST_NOFIT;
                RES_FULL:  r_res_st <= ST_FULL;
                default:   r_res_st <= ST_OK;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_st;
            r_o_off    <= r_res_off;
            r_o_len    <= r_res_len;
        end
    end

    assign o_stat.act        = r_act;
    assign o_stat.idx_lt_cnt = r_idx < r_count;
    assign o_stat.j_lt_cnt   = r_j < r_count;
    assign o_stat.j_gt_idx   = r_j > r_idx;
    assign o_stat.mod_busy   = r_mbusy;
    assign o_stat.fit        = w_need <= {1'b0, r_cur_l};
    assign o_stat.nl_zero    = w_new_l == '0;
    assign o_stat.start_lt   = r_cur_s < r_off;
    assign o_stat.mnext      = meets(r_off, r_size, r_cur_s);
    assign o_stat.mprev      = (r_idx != '0) && meets(r_prv_s, r_prv_l, r_off);
    assign o_stat.full       = r_count >= CW'(MAX_REGIONS);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_region_offset = r_o_off;
    assign o_region_length = r_o_len;
endmodule

FILE: rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// request sequencer: table scan, alignment wait, shift passes and result hand-off
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ffra_pkg::t_ffra_stat  i_stat,
    output ffra_pkg::t_ffra_cmd   o_cmd
);
    import ffra_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_LAT    = 4'd2;
    localparam logic [3:0] S_MOD    = 4'd3;
    localparam logic [3:0] S_FIT    = 4'd4;
    localparam logic [3:0] S_FCMP   = 4'd5;
    localparam logic [3:0] S_FDEC   = 4'd6;
    localparam logic [3:0] S_DN_RD  = 4'd7;
    localparam logic [3:0] S_DN_WR  = 4'd8;
    localparam logic [3:0] S_DN_END = 4'd9;
    localparam logic [3:0] S_UP_RD  = 4'd10;
    localparam logic [3:0] S_UP_WR  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.idx_lt_cnt) begin
                    o_cmd.rsel  = RA_IDX;
                    n_state     = S_LAT;
                end else if (i_stat.act) begin
                    n_state = S_FDEC;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = RES_NOFIT;
                    n_state        = S_OUT;
                end
            end
            S_LAT: begin
                o_cmd.lat_cur = 1'b1;
                n_state       = i_stat.act ? S_FCMP : S_MOD;
            end
            S_MOD: begin
                if (!i_stat.mod_busy) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (i_stat.fit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = RES_GRANT;
                    if (i_stat.nl_zero) begin
                        o_cmd.j_set_idx1 = 1'b1;
                        n_state          = S_DN_RD;
                    end else begin
                        o_cmd.wsel = W_ALLOC;
                        n_state    = S_OUT;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_FCMP: begin
                if (i_stat.start_lt) begin
                    o_cmd.prv_from_cur = 1'b1;
                    o_cmd.idx_inc      = 1'b1;
                    n_state            = S_RD;
                end else begin
                    n_state = S_FDEC;
                end
            end
            S_FDEC: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = RES_NONE;
                if (i_stat.idx_lt_cnt && i_stat.mnext) begin
                    if (i_stat.mprev) begin
                        o_cmd.wsel       = W_MBOTH;
                        o_cmd.j_set_idx1 = 1'b1;
                        n_state          = S_DN_RD;
                    end else begin
                        o_cmd.wsel = W_MNEXT;
                        n_state    = S_OUT;
                    end
                end else if (i_stat.mprev) begin
                    o_cmd.wsel = W_MPREV;
                    n_state    = S_OUT;
                end else if (i_stat.full) begin
                    o_cmd.res_code = RES_FULL;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.j_set_cnt = 1'b1;
                    n_state         = S_UP_RD;
                end
            end
            S_DN_RD: begin
                if (i_stat.j_lt_cnt) begin
                    o_cmd.rsel  = RA_J;
                    n_state     = S_DN_WR;
                end else begin
                    n_state = S_DN_END;
                end
            end
            S_DN_WR: begin
                o_cmd.wsel  = W_DN;
                o_cmd.j_inc = 1'b1;
                n_state     = S_DN_RD;
            end
            S_DN_END: begin
                o_cmd.cnt_dec = 1'b1;
                n_state       = S_OUT;
            end
            S_UP_RD: begin
                if (i_stat.j_gt_idx) begin
                    o_cmd.rsel  = RA_JM1;
                    n_state     = S_UP_WR;
                end else begin
                    o_cmd.wsel    = W_INS;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_UP_WR: begin
                o_cmd.wsel  = W_UP;
                o_cmd.j_dec = 1'b1;
                n_state     = S_UP_RD;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
